// ----- rtl/speed_pid_filtered_derivative_macros.svh -----
// Assertion macros shared by the checker of the speed loop.
// Depends on nothing; the files that assert take it by include.
`ifndef SPEED_PID_FILTERED_DERIVATIVE_MACROS_SVH
`define SPEED_PID_FILTERED_DERIVATIVE_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define SPD_ASSERT_NEXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define SPD_ASSERT_NOW(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ----- rtl/spd_pkg.sv -----
// Shared types and constants of the speed loop with filtered derivative.
// Used by spd_cfg, spd_mac, the top level and the checker; depends on nothing.
package spd_pkg;

	localparam int SPEED_BITS_DEF = 24;

	// Configuration port
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_P_GAIN    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_I_GAIN    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_D_GAIN    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_D_COEFF   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED = 3'd4;

	localparam int GAIN_W   = 32;
	localparam int COEFF_W  = 17;
	localparam int MINSPD_W = 23;
	localparam logic [COEFF_W-1:0]  COEFF_ONE  = 17'd65536;
	localparam logic [MINSPD_W-1:0] MINSPD_RST = 23'd20;

	// Shared multiply-accumulate unit
	localparam int CHUNK_W = 17;
	localparam int MUL_B_W = 32;
	localparam int PROD_W  = CHUNK_W + MUL_B_W;
	localparam int MAG_W   = 2 * CHUNK_W;
	localparam int ACC_W   = MAG_W + MUL_B_W;
	localparam logic [1:0] SH_0  = 2'd0;
	localparam logic [1:0] SH_17 = 2'd1;
	localparam logic [1:0] SH_32 = 2'd2;

	// Datapath
	localparam int D_W     = 48;
	localparam int DRIVE_W = 17;
	localparam int OUT_W   = 24;
	localparam logic [31:0]    ONE_Q30 = 32'h4000_0000;
	localparam logic [D_W-2:0] DMAX    = '1;

	typedef struct packed {
		logic [GAIN_W-1:0]   p_gain;
		logic [GAIN_W-1:0]   i_gain;
		logic [GAIN_W-1:0]   d_gain;
		logic [COEFF_W-1:0]  coeff;
		logic [MINSPD_W-1:0] min_speed;
	} cfg_t;

	typedef struct packed {
		logic       en;
		logic       clr;
		logic [1:0] sh;
	} mac_ctl_t;

endpackage

// ----- rtl/spd_cfg.sv -----
// Configuration registers of the speed loop, written through a plain write port.
// Depends on spd_pkg.
module spd_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [spd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [spd_pkg::CFG_W-1:0]      cfg_data,
	output spd_pkg::cfg_t                  cfg
);

	logic [spd_pkg::GAIN_W-1:0]   p_gain_q;
	logic [spd_pkg::GAIN_W-1:0]   i_gain_q;
	logic [spd_pkg::GAIN_W-1:0]   d_gain_q;
	logic [spd_pkg::COEFF_W-1:0]  coeff_q;
	logic [spd_pkg::MINSPD_W-1:0] min_speed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_gain_q    <= '0;
			i_gain_q    <= '0;
			d_gain_q    <= '0;
			coeff_q     <= spd_pkg::COEFF_ONE;
			min_speed_q <= spd_pkg::MINSPD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				spd_pkg::REG_P_GAIN:    p_gain_q    <= cfg_data[spd_pkg::GAIN_W-1:0];
				spd_pkg::REG_I_GAIN:    i_gain_q    <= cfg_data[spd_pkg::GAIN_W-1:0];
				spd_pkg::REG_D_GAIN:    d_gain_q    <= cfg_data[spd_pkg::GAIN_W-1:0];
				spd_pkg::REG_D_COEFF:   coeff_q     <= cfg_data[spd_pkg::COEFF_W-1:0];
				spd_pkg::REG_MIN_SPEED: min_speed_q <= cfg_data[spd_pkg::MINSPD_W-1:0];
				default: ;
			endcase
		end
	end

	// A coefficient above one behaves as one, so it is saturated here once.
	always_comb begin
		cfg.p_gain    = p_gain_q;
		cfg.i_gain    = i_gain_q;
		cfg.d_gain    = d_gain_q;
		cfg.coeff     = (coeff_q > spd_pkg::COEFF_ONE) ? spd_pkg::COEFF_ONE : coeff_q;
		cfg.min_speed = min_speed_q;
	end

endmodule

// ----- rtl/spd_mac.sv -----
// Shared 17 x 32 bit unsigned multiply-accumulate unit with a selectable shift.
// Depends on spd_pkg.
module spd_mac (
	input  logic                          clk,
	input  spd_pkg::mac_ctl_t             ctl,
	input  logic [spd_pkg::CHUNK_W-1:0]   a,
	input  logic [spd_pkg::MUL_B_W-1:0]   b,
	output logic [spd_pkg::ACC_W-1:0]     acc
);

	logic [spd_pkg::PROD_W-1:0] prod;
	logic [spd_pkg::ACC_W-1:0]  term;
	logic [spd_pkg::ACC_W-1:0]  acc_q;

	assign prod = spd_pkg::PROD_W'(a) * spd_pkg::PROD_W'(b);

	always_comb begin
		unique case (ctl.sh)
			spd_pkg::SH_0:  term = spd_pkg::ACC_W'(prod);
			spd_pkg::SH_17: term = spd_pkg::ACC_W'({prod, 17'b0});
			spd_pkg::SH_32: term = spd_pkg::ACC_W'({prod, 32'b0});
			default:        term = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			acc_q <= (ctl.clr ? '0 : acc_q) + term;
		end
	end

	assign acc = acc_q;

endmodule

// ----- rtl/speed_pid_filtered_derivative.sv -----
// Speed PID loop with a low-passed derivative and a clamped integral.
// Requests arrive on the s_ stream: tdata holds setpoint in the low SPEED_BITS
// bits and measured speed in the next SPEED_BITS bits, zero-filled to bytes.
// Results leave on the m_ stream: tdata holds the Q1.15 drive in bits 16:0,
// tuser is the held flag. Gains and filter settings come in on the cfg_ port,
// one register per write; the user must change them only while no request is
// in flight (the block does not enforce it). One request at a time: s_tready
// is high only when the sequencer is idle. A normal request walks through 17
// sequencer steps before m_tvalid rises, and the sequencer is back in idle
// as m_tvalid rises. The step count is set by the single shared 17 x 32
// multiplier, which forms the P, I and D products in two halves each and the
// filter step in two more, plus the sign, clamp and sum steps. A resting request
// (setpoint magnitude below min_speed) goes from the check step to the output step.
// The result waits in an output register; if the receiver stalls, the
// sequencer holds in its last step until the register frees up.
// Reset clears the integral, previous error, filtered derivative and last
// drive, and loads the register defaults (gains zero, coefficient one,
// min_speed 20).
// Depends on spd_pkg, spd_cfg and spd_mac.
module speed_pid_filtered_derivative #(
	parameter int SPEED_BITS = spd_pkg::SPEED_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// setpoint, measured
	input  logic [((2*SPEED_BITS+7)/8)*8-1:0]      s_tdata,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// drive, zero fill
	output logic [spd_pkg::OUT_W-1:0]              m_tdata,
	// held
	output logic                                   m_tuser,
	input  logic                                   cfg_we,
	input  logic [spd_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [spd_pkg::CFG_W-1:0]              cfg_data
);

	localparam int S   = SPEED_BITS;
	localparam int EW  = S + 1;
	localparam int DW  = S + 2;
	localparam int TW  = S + 31;
	localparam int IW  = S + 32;
	localparam int SW  = ((IW > spd_pkg::D_W) ? IW : spd_pkg::D_W) + 1;
	localparam int FW  = spd_pkg::D_W + 2;
	localparam int CW  = (S > spd_pkg::MINSPD_W) ? S : spd_pkg::MINSPD_W;
	localparam int DRW = spd_pkg::DRIVE_W;

	localparam logic signed [IW-1:0] ONE_I   = IW'(spd_pkg::ONE_Q30);
	localparam logic signed [SW-1:0] ONE_S   = SW'(spd_pkg::ONE_Q30);
	localparam logic signed [FW-1:0] DMAX_F  = FW'(spd_pkg::DMAX);

	localparam logic [4:0] ST_IDLE  = 5'd0;
	localparam logic [4:0] ST_CHECK = 5'd1;
	localparam logic [4:0] ST_MAG   = 5'd2;
	localparam logic [4:0] ST_P0    = 5'd3;
	localparam logic [4:0] ST_P1    = 5'd4;
	localparam logic [4:0] ST_I0    = 5'd5;
	localparam logic [4:0] ST_I1    = 5'd6;
	localparam logic [4:0] ST_D0    = 5'd7;
	localparam logic [4:0] ST_D1    = 5'd8;
	localparam logic [4:0] ST_DCAP  = 5'd9;
	localparam logic [4:0] ST_FDIF  = 5'd10;
	localparam logic [4:0] ST_FMAG  = 5'd11;
	localparam logic [4:0] ST_F0    = 5'd12;
	localparam logic [4:0] ST_F1    = 5'd13;
	localparam logic [4:0] ST_FUPD  = 5'd14;
	localparam logic [4:0] ST_SUM   = 5'd15;
	localparam logic [4:0] ST_DRV   = 5'd16;
	localparam logic [4:0] ST_OUT   = 5'd17;

	spd_pkg::cfg_t     cfg;
	spd_pkg::mac_ctl_t mac_ctl;
	logic [spd_pkg::CHUNK_W-1:0] mac_a;
	logic [spd_pkg::MUL_B_W-1:0] mac_b;
	logic [spd_pkg::ACC_W-1:0]   acc;

	logic [4:0] state_q, state_d;

	// Working registers of one request
	logic signed [S-1:0]             sp_q;
	logic signed [EW-1:0]            err_q;
	logic signed [DW-1:0]            diff_q;
	logic [EW-1:0]                   emag_q;
	logic                            esign_q;
	logic [DW-1:0]                   dmag_q;
	logic                            dsign_q;
	logic signed [TW-1:0]            p_q;
	logic signed [IW-1:0]            sum1_q;
	logic signed [spd_pkg::D_W-1:0]  d_q;
	logic signed [spd_pkg::D_W:0]    fdiff_q;
	logic [spd_pkg::D_W-1:0]         fmag_q;
	logic                            fsign_q;
	logic signed [31:0]              sumc_q;
	logic [DRW-1:0]                  res_drive_q;
	logic                            res_held_q;

	// Loop state
	logic signed [31:0]              integral_q;
	logic signed [EW-1:0]            prev_q;
	logic signed [spd_pkg::D_W-1:0]  fd_q;
	logic [DRW-1:0]                  last_drive_q;

	// Output register
	logic                            out_valid_q;
	logic [DRW-1:0]                  out_drive_q;
	logic                            out_held_q;

	logic signed [S-1:0]  sp_in, meas_in;
	logic signed [S:0]    sp_x, sp_abs;
	logic [S-1:0]         sp_mag;
	logic                 rest;
	logic signed [EW-1:0] err_abs;
	logic signed [DW-1:0] diff_abs;
	logic [S+29:0]        prod_mag;
	logic signed [TW-1:0] prod_term;
	logic signed [IW-1:0] isum;
	logic [63:0]          dfull;
	logic [spd_pkg::D_W-2:0]        dcap;
	logic signed [spd_pkg::D_W-1:0] d_val;
	logic signed [spd_pkg::D_W:0]   fdiff_abs;
	logic [spd_pkg::D_W-1:0]        fstep;
	logic signed [FW-1:0] fnew;
	logic signed [SW-1:0] sum_all;
	logic signed [31:0]   sumc_abs;
	logic [DRW-1:0]       drv_mag;
	logic                 load_out;

	spd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	spd_mac u_mac (
		.clk (clk),
		.ctl (mac_ctl),
		.a   (mac_a),
		.b   (mac_b),
		.acc (acc)
	);

	assign sp_in   = s_tdata[S-1:0];
	assign meas_in = s_tdata[2*S-1:S];

	assign s_tready = (state_q == ST_IDLE);
	assign load_out = (state_q == ST_OUT) && (!out_valid_q || m_tready);

	// Resting test on the setpoint magnitude.
	assign sp_x   = (S+1)'(sp_q);
	assign sp_abs = sp_q[S-1] ? -sp_x : sp_x;
	assign sp_mag = sp_abs[S-1:0];
	assign rest   = CW'(sp_mag) < CW'(cfg.min_speed);

	assign err_abs  = err_q[EW-1] ? -err_q : err_q;
	assign diff_abs = diff_q[DW-1] ? -diff_q : diff_q;

	// Gain products are Q0.32 times an integer, so dropping two bits gives Q.30.
	assign prod_mag  = acc[S+31:2];
	assign prod_term = esign_q ? -$signed({1'b0, prod_mag}) : $signed({1'b0, prod_mag});
	assign isum      = IW'(integral_q) + IW'(prod_term);

	assign dfull = acc[spd_pkg::ACC_W-1:2];
	assign dcap  = (dfull > 64'(spd_pkg::DMAX)) ? spd_pkg::DMAX : dfull[spd_pkg::D_W-2:0];
	assign d_val = dsign_q ? -$signed({1'b0, dcap}) : $signed({1'b0, dcap});

	assign fdiff_abs = fdiff_q[spd_pkg::D_W] ? -fdiff_q : fdiff_q;
	assign fstep     = acc[spd_pkg::D_W+15:16];
	assign fnew      = fsign_q ? (FW'(fd_q) + $signed({2'b0, fstep}))
	                           : (FW'(fd_q) - $signed({2'b0, fstep}));

	assign sum_all  = SW'(sum1_q) + SW'(fd_q);
	assign sumc_abs = sumc_q[31] ? -sumc_q : sumc_q;
	assign drv_mag  = sumc_abs[31:15];

	// Sequencer and operand selection for the shared multiplier.
	always_comb begin
		state_d     = state_q;
		mac_ctl.en  = 1'b0;
		mac_ctl.clr = 1'b0;
		mac_ctl.sh  = spd_pkg::SH_0;
		mac_a       = '0;
		mac_b       = '0;
		unique case (state_q)
			ST_IDLE:  if (s_tvalid) state_d = ST_CHECK;
			ST_CHECK: state_d = rest ? ST_OUT : ST_MAG;
			ST_MAG:   state_d = ST_P0;
			ST_P0: begin
				mac_ctl = '{en: 1'b1, clr: 1'b1, sh: spd_pkg::SH_0};
				mac_a   = spd_pkg::CHUNK_W'(emag_q);
				mac_b   = cfg.p_gain;
				state_d = ST_P1;
			end
			ST_P1: begin
				mac_ctl = '{en: 1'b1, clr: 1'b0, sh: spd_pkg::SH_17};
				mac_a   = spd_pkg::CHUNK_W'(spd_pkg::MAG_W'(emag_q) >> spd_pkg::CHUNK_W);
				mac_b   = cfg.p_gain;
				state_d = ST_I0;
			end
			ST_I0: begin
				mac_ctl = '{en: 1'b1, clr: 1'b1, sh: spd_pkg::SH_0};
				mac_a   = spd_pkg::CHUNK_W'(emag_q);
				mac_b   = cfg.i_gain;
				state_d = ST_I1;
			end
			ST_I1: begin
				mac_ctl = '{en: 1'b1, clr: 1'b0, sh: spd_pkg::SH_17};
				mac_a   = spd_pkg::CHUNK_W'(spd_pkg::MAG_W'(emag_q) >> spd_pkg::CHUNK_W);
				mac_b   = cfg.i_gain;
				state_d = ST_D0;
			end
			ST_D0: begin
				mac_ctl = '{en: 1'b1, clr: 1'b1, sh: spd_pkg::SH_0};
				mac_a   = spd_pkg::CHUNK_W'(dmag_q);
				mac_b   = cfg.d_gain;
				state_d = ST_D1;
			end
			ST_D1: begin
				mac_ctl = '{en: 1'b1, clr: 1'b0, sh: spd_pkg::SH_17};
				mac_a   = spd_pkg::CHUNK_W'(spd_pkg::MAG_W'(dmag_q) >> spd_pkg::CHUNK_W);
				mac_b   = cfg.d_gain;
				state_d = ST_DCAP;
			end
			ST_DCAP: state_d = ST_FDIF;
			ST_FDIF: state_d = ST_FMAG;
			ST_FMAG: state_d = ST_F0;
			ST_F0: begin
				mac_ctl = '{en: 1'b1, clr: 1'b1, sh: spd_pkg::SH_0};
				mac_a   = cfg.coeff;
				mac_b   = fmag_q[spd_pkg::MUL_B_W-1:0];
				state_d = ST_F1;
			end
			ST_F1: begin
				mac_ctl = '{en: 1'b1, clr: 1'b0, sh: spd_pkg::SH_32};
				mac_a   = cfg.coeff;
				mac_b   = spd_pkg::MUL_B_W'(fmag_q[spd_pkg::D_W-1:spd_pkg::MUL_B_W]);
				state_d = ST_FUPD;
			end
			ST_FUPD: state_d = ST_SUM;
			ST_SUM:  state_d = ST_DRV;
			ST_DRV:  state_d = ST_OUT;
			ST_OUT:  if (load_out) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			out_valid_q  <= 1'b0;
			integral_q   <= '0;
			prev_q       <= '0;
			fd_q         <= '0;
			last_drive_q <= '0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_CHECK) begin
				prev_q <= err_q;
				if (rest) begin
					integral_q <= '0;
				end
			end
			if (state_q == ST_D0) begin
				// The integral step is in the accumulator; clamp the new sum to plus and minus one.
				if (isum > ONE_I) begin
					integral_q <= 32'(ONE_I);
				end else if (isum < -ONE_I) begin
					integral_q <= 32'(-ONE_I);
				end else begin
					integral_q <= isum[31:0];
				end
			end
			if (state_q == ST_FUPD) begin
				if (fnew > DMAX_F) begin
					fd_q <= spd_pkg::D_W'(DMAX_F);
				end else if (fnew < -DMAX_F) begin
					fd_q <= spd_pkg::D_W'(-DMAX_F);
				end else begin
					fd_q <= fnew[spd_pkg::D_W-1:0];
				end
			end
			if (state_q == ST_DRV) begin
				last_drive_q <= sumc_q[31] ? -drv_mag : drv_mag;
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				sp_q  <= sp_in;
				err_q <= EW'(sp_in) - EW'(meas_in);
			end
			ST_CHECK: begin
				diff_q     <= DW'(err_q) - DW'(prev_q);
				emag_q     <= err_abs;
				esign_q    <= err_q[EW-1];
				res_drive_q <= last_drive_q;
				res_held_q  <= 1'b1;
			end
			ST_MAG: begin
				dmag_q  <= diff_abs;
				dsign_q <= diff_q[DW-1];
			end
			ST_I0:   p_q     <= prod_term;
			ST_DCAP: begin
				d_q    <= d_val;
				sum1_q <= IW'(p_q) + IW'(integral_q);
			end
			ST_FDIF: fdiff_q <= (spd_pkg::D_W+1)'(fd_q) - (spd_pkg::D_W+1)'(d_q);
			ST_FMAG: begin
				fmag_q  <= fdiff_abs[spd_pkg::D_W-1:0];
				fsign_q <= fdiff_q[spd_pkg::D_W];
			end
			ST_SUM: begin
				if (sum_all > ONE_S) begin
					sumc_q <= 32'(ONE_S);
				end else if (sum_all < -ONE_S) begin
					sumc_q <= 32'(-ONE_S);
				end else begin
					sumc_q <= sum_all[31:0];
				end
			end
			ST_DRV: begin
				res_drive_q <= sumc_q[31] ? -drv_mag : drv_mag;
				res_held_q  <= 1'b0;
			end
			default: ;
		endcase
		if (load_out) begin
			out_drive_q <= res_drive_q;
			out_held_q  <= res_held_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = spd_pkg::OUT_W'(out_drive_q);
	assign m_tuser  = out_held_q;

endmodule

// ----- rtl/spd_checker.sv -----
// Port-level checks of the speed loop, bound to the top level.
// Depends on speed_pid_filtered_derivative_macros.svh and spd_pkg.
`include "speed_pid_filtered_derivative_macros.svh"

module spd_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [spd_pkg::OUT_W-1:0]   m_tdata,
	input logic                        m_tuser
);

	// A stalled result keeps its value.
	`SPD_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

	// One request at a time: the port closes right after a request is taken.
	`SPD_ASSERT_NEXT(a_busy_after_req, clk, arst_n, s_tvalid && s_tready, !s_tready, "second request taken while busy")

	// A new result only appears from the output step, when the input side is closed.
	`SPD_ASSERT_NOW(a_result_source, clk, arst_n, $rose(m_tvalid), $past(!s_tready), "result appeared without a finished request")

	// The drive stays within plus and minus one and the fill bits stay zero.
	`SPD_ASSERT_NOW(a_drive_range, clk, arst_n, m_tvalid, (m_tdata[23:17] == 7'd0) && (m_tdata[16] ? m_tdata[15] : (!m_tdata[15] || (m_tdata[14:0] == 15'd0))), "drive out of range")

endmodule

bind speed_pid_filtered_derivative spd_checker u_spd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
